// File: hw/rtl/gdz_pkg.sv
// ----------------------------------------------------------------------------
// gdz_pkg: shared types and constants
// Payload structs, event codes and register indexes of the gamepad
// dead-zone change-event block.
// ----------------------------------------------------------------------------
package gdz_pkg;

   typedef struct packed {
      logic               controller_present;
      logic        [31:0] packet_number;
      logic        [15:0] button_word;
      logic        [7:0]  left_trigger_raw;
      logic        [7:0]  right_trigger_raw;
      logic signed [15:0] left_x_raw;
      logic signed [15:0] left_y_raw;
      logic signed [15:0] right_x_raw;
      logic signed [15:0] right_y_raw;
   } req_type;

   typedef struct packed {
      logic        [2:0]  event_kind;
      logic        [3:0]  button_bit;
      logic               button_pressed;
      logic signed [15:0] value_x;
      logic signed [15:0] value_y;
      logic               last_event;
   } rsp_type;

   // One event handed from the front to the back
   typedef struct packed {
      logic        [2:0]  kind;
      logic        [3:0]  bit_pos;
      logic               pressed;
      logic               last;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic        [14:0] dz;
   } job_type;

   localparam logic [2:0] EV_ESTABLISHED = 3'd0;
   localparam logic [2:0] EV_LOST        = 3'd1;
   localparam logic [2:0] EV_BUTTON      = 3'd2;
   localparam logic [2:0] EV_LTRIG       = 3'd3;
   localparam logic [2:0] EV_RTRIG       = 3'd4;
   localparam logic [2:0] EV_LSTICK      = 3'd5;
   localparam logic [2:0] EV_RSTICK      = 3'd6;

   localparam logic [1:0] CSR_TRIG_DZ  = 2'd0;
   localparam logic [1:0] CSR_LEFT_DZ  = 2'd1;
   localparam logic [1:0] CSR_RIGHT_DZ = 2'd2;

   localparam logic [14:0] LEFT_DZ_RESET  = 15'd7848;
   localparam logic [14:0] RIGHT_DZ_RESET = 15'd8688;
   localparam logic [15:0] BUTTON_EVENT_MASK = 16'hF3FF;
   localparam logic [14:0] AXIS_FULL    = 15'd32767;
   localparam logic [14:0] TRIGGER_FULL = 15'd255;

endpackage

// File: hw/rtl/gdz_queue.sv
// ----------------------------------------------------------------------------
// gdz_queue: event queue
// Short first-in first-out queue of events between the front and the back.
// ----------------------------------------------------------------------------
module gdz_queue
   import gdz_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   job_type    mem_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;
   logic       do_push, do_pop;

   assign full     = (count_ff == 3'd4);
   assign empty    = (count_ff == 3'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + {2'b0, do_push} - {2'b0, do_pop};
      end
   end

endmodule

// File: hw/rtl/gdz_front.sv
// ----------------------------------------------------------------------------
// gdz_front: sample classifier
// Compares each sample with the stored one, updates the stored sample and
// hands the resulting events to the queue in order, stalling while it is full.
// ----------------------------------------------------------------------------
module gdz_front
   import gdz_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   input  logic [7:0]  trig_dz,
   input  logic [14:0] left_dz,
   input  logic [14:0] right_dz,
   output logic        job_push,
   output job_type     job_data,
   input  logic        job_full
);

   // Stored sample
   logic               was_ff, was_in;
   logic        [31:0] prev_pkt_ff, prev_pkt_in;
   logic        [15:0] prev_btn_ff, prev_btn_in;
   logic        [7:0]  prev_t0_ff, prev_t0_in, prev_t1_ff, prev_t1_in;
   logic signed [15:0] prev_ax_ff [4];
   logic signed [15:0] prev_ax_in [4];
   // Event scan
   logic        [20:0] mask_ff, mask_in;
   logic        [4:0]  idx_ff, idx_in;
   logic               lost_ff, lost_in;
   // New values computed at accept
   logic        [7:0]  t0_n, t1_n;
   logic signed [15:0] ax_n [4];
   logic        [15:0] changed;
   logic               accept;
   logic        [20:0] upper_mask;

   function automatic logic signed [15:0] axis_dz(logic signed [15:0] a,
                                                 logic [14:0] dz);
      logic [16:0] m;
      m = a[15] ? (17'd0 - {a[15], a}) : {1'b0, a};
      if (m <= {2'b0, dz})     return 16'sd0;
      else if (a == 16'sh8000) return -16'sd32767;
      else                     return a;
   endfunction

   assign accept   = req_push && !req_full;
   assign req_full = |mask_ff;

   // Dead zones of the new sample
   always_comb begin
      t0_n    = (req_data.left_trigger_raw  <= trig_dz) ? 8'd0 : req_data.left_trigger_raw;
      t1_n    = (req_data.right_trigger_raw <= trig_dz) ? 8'd0 : req_data.right_trigger_raw;
      ax_n[0] = axis_dz(req_data.left_x_raw,  left_dz);
      ax_n[1] = axis_dz(req_data.left_y_raw,  left_dz);
      ax_n[2] = axis_dz(req_data.right_x_raw, right_dz);
      ax_n[3] = axis_dz(req_data.right_y_raw, right_dz);
      changed = (req_data.button_word ^ prev_btn_ff) & BUTTON_EVENT_MASK;
   end

   // Classify on accept, then scan pending events
   always_comb begin
      logic proc;
      proc        = 1'b0;
      was_in      = was_ff;
      prev_pkt_in = prev_pkt_ff;
      prev_btn_in = prev_btn_ff;
      prev_t0_in  = prev_t0_ff;
      prev_t1_in  = prev_t1_ff;
      prev_ax_in  = prev_ax_ff;
      mask_in     = mask_ff;
      idx_in      = idx_ff;
      lost_in     = lost_ff;
      job_push    = 1'b0;
      if (accept) begin
         idx_in  = '0;
         lost_in = 1'b0;
         mask_in = '0;
         if (!was_ff) begin
            if (req_data.controller_present) begin
               was_in     = 1'b1;
               mask_in[0] = 1'b1;
               proc       = 1'b1;
            end
         end else if (!req_data.controller_present) begin
            was_in      = 1'b0;
            prev_pkt_in = '0;
            prev_btn_in = '0;
            prev_t0_in  = '0;
            prev_t1_in  = '0;
            prev_ax_in  = '{default: '0};
            mask_in[0]  = 1'b1;
            lost_in     = 1'b1;
         end else begin
            proc = 1'b1;
         end
         if (proc && (req_data.packet_number != prev_pkt_ff)) begin
            mask_in[16:1] = changed;
            mask_in[17]   = (t0_n != prev_t0_ff);
            mask_in[18]   = (t1_n != prev_t1_ff);
            mask_in[19]   = (ax_n[0] != prev_ax_ff[0]) || (ax_n[1] != prev_ax_ff[1]);
            mask_in[20]   = (ax_n[2] != prev_ax_ff[2]) || (ax_n[3] != prev_ax_ff[3]);
            prev_pkt_in   = req_data.packet_number;
            prev_btn_in   = req_data.button_word;
            prev_t0_in    = t0_n;
            prev_t1_in    = t1_n;
            prev_ax_in    = ax_n;
         end
      end else if (|mask_ff) begin
         if (!mask_ff[idx_ff] || !job_full) idx_in = idx_ff + 5'd1;
         if (mask_ff[idx_ff] && !job_full) begin
            mask_in[idx_ff] = 1'b0;
            job_push        = 1'b1;
         end
      end
   end

   // Build the event at the scan position
   assign upper_mask = ~(21'((22'd2 << idx_ff) - 22'd1));

   always_comb begin
      job_data         = '0;
      job_data.last    = ~|(mask_ff & upper_mask);
      unique case (idx_ff) inside
         5'd0: begin
            job_data.kind = lost_ff ? EV_LOST : EV_ESTABLISHED;
         end
         [5'd1:5'd16]: begin
            job_data.kind    = EV_BUTTON;
            job_data.bit_pos = 4'(idx_ff - 5'd1);
            job_data.pressed = prev_btn_ff[4'(idx_ff - 5'd1)];
         end
         5'd17: begin
            job_data.kind = EV_LTRIG;
            job_data.a    = {8'd0, prev_t0_ff};
            job_data.dz   = {7'd0, trig_dz};
         end
         5'd18: begin
            job_data.kind = EV_RTRIG;
            job_data.a    = {8'd0, prev_t1_ff};
            job_data.dz   = {7'd0, trig_dz};
         end
         5'd19: begin
            job_data.kind = EV_LSTICK;
            job_data.a    = prev_ax_ff[0];
            job_data.b    = prev_ax_ff[1];
            job_data.dz   = left_dz;
         end
         5'd20: begin
            job_data.kind = EV_RSTICK;
            job_data.a    = prev_ax_ff[2];
            job_data.b    = prev_ax_ff[3];
            job_data.dz   = right_dz;
         end
         default: begin
            job_data.kind = EV_ESTABLISHED;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         was_ff      <= 1'b0;
         prev_pkt_ff <= '0;
         prev_btn_ff <= '0;
         prev_t0_ff  <= '0;
         prev_t1_ff  <= '0;
         prev_ax_ff  <= '{default: '0};
         mask_ff     <= '0;
         idx_ff      <= '0;
         lost_ff     <= 1'b0;
      end else begin
         was_ff      <= was_in;
         prev_pkt_ff <= prev_pkt_in;
         prev_btn_ff <= prev_btn_in;
         prev_t0_ff  <= prev_t0_in;
         prev_t1_ff  <= prev_t1_in;
         prev_ax_ff  <= prev_ax_in;
         mask_ff     <= mask_in;
         idx_ff      <= idx_in;
         lost_ff     <= lost_in;
      end
   end

endmodule

// File: hw/rtl/gdz_back.sv
// ----------------------------------------------------------------------------
// gdz_back: event scaler
// Rescales trigger and stick values with a shared bit-serial divider and
// holds each finished event in the output register.
// ----------------------------------------------------------------------------
module gdz_back
   import gdz_pkg::*;
#(
   parameter int VALUE_FRACTION_BITS = 14
) (
   input  logic    clock,
   input  logic    reset,
   input  job_type job_data,
   input  logic    job_empty,
   output logic    job_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(VALUE_FRACTION_BITS + 1);
   localparam logic [15:0] ONE_VAL =
      ((1 << VALUE_FRACTION_BITS) > 32767) ? 16'd32767 : 16'(1 << VALUE_FRACTION_BITS);

   typedef enum logic [2:0] {B_IDLE, B_SETUP, B_DIV, B_STORE, B_PUSH} state_type;

   state_type          state_ff;
   job_type            job_ff;
   logic               sel_ff, neg_ff;
   logic        [14:0] rem_ff, div_ff;
   logic        [15:0] q_ff;
   logic        [CW-1:0] cnt_ff;
   logic signed [15:0] x_ff, y_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic signed [15:0] cur;
   logic        [15:0] cur_abs;
   logic        [14:0] mag, full;
   logic        [15:0] rem2;
   logic               is_trig, is_stick;

   assign job_pop   = (state_ff == B_IDLE) && !job_empty;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_trig  = (job_ff.kind == EV_LTRIG) || (job_ff.kind == EV_RTRIG);
   assign is_stick = (job_ff.kind == EV_LSTICK) || (job_ff.kind == EV_RSTICK);
   assign cur      = sel_ff ? job_ff.b : job_ff.a;
   assign cur_abs  = cur[15] ? 16'(-cur) : cur;
   assign mag      = cur_abs[14:0];
   assign full     = is_trig ? TRIGGER_FULL : AXIS_FULL;
   assign rem2     = {rem_ff, 1'b0};

   // Sequence one event: setup, divide, store (twice for a stick), push; no-value events only push
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the popped beat unless a new one loads in the same cycle
         if (rsp_pop && rsp_valid_ff && (state_ff != B_PUSH)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (!job_empty) begin
                  job_ff <= job_data;
                  sel_ff <= 1'b0;
                  x_ff   <= '0;
                  y_ff   <= '0;
                  if ((job_data.kind == EV_LTRIG) || (job_data.kind == EV_RTRIG) ||
                      (job_data.kind == EV_LSTICK) || (job_data.kind == EV_RSTICK)) begin
                     state_ff <= B_SETUP;
                  end else begin
                     state_ff <= B_PUSH;
                  end
               end
            end
            B_SETUP: begin
               neg_ff <= cur[15];
               if (mag <= job_ff.dz) begin
                  q_ff     <= '0;
                  state_ff <= B_STORE;
               end else if (mag >= full) begin
                  q_ff     <= ONE_VAL;
                  state_ff <= B_STORE;
               end else begin
                  rem_ff   <= mag - job_ff.dz;
                  div_ff   <= full - job_ff.dz;
                  q_ff     <= '0;
                  cnt_ff   <= CW'(VALUE_FRACTION_BITS);
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               if (rem2 >= {1'b0, div_ff}) begin
                  rem_ff <= 15'(rem2 - {1'b0, div_ff});
                  q_ff   <= {q_ff[14:0], 1'b1};
               end else begin
                  rem_ff <= rem2[14:0];
                  q_ff   <= {q_ff[14:0], 1'b0};
               end
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) state_ff <= B_STORE;
            end
            B_STORE: begin
               if (!sel_ff) begin
                  x_ff <= neg_ff ? $signed(16'(-q_ff)) : $signed(q_ff);
                  if (is_stick) begin
                     sel_ff   <= 1'b1;
                     state_ff <= B_SETUP;
                  end else begin
                     state_ff <= B_PUSH;
                  end
               end else begin
                  y_ff     <= neg_ff ? $signed(q_ff) : $signed(16'(-q_ff));
                  state_ff <= B_PUSH;
               end
            end
            B_PUSH: begin
               if (!rsp_valid_ff || rsp_pop) begin
                  rsp_valid_ff               <= 1'b1;
                  rsp_data_ff.event_kind     <= job_ff.kind;
                  rsp_data_ff.button_bit     <= job_ff.bit_pos;
                  rsp_data_ff.button_pressed <= job_ff.pressed;
                  rsp_data_ff.value_x        <= x_ff;
                  rsp_data_ff.value_y        <= y_ff;
                  rsp_data_ff.last_event     <= job_ff.last;
                  state_ff                   <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// File: hw/rtl/gamepad_dead_zone_change_events.sv
// ----------------------------------------------------------------------------
// gamepad_dead_zone_change_events: gamepad change-event emitter
// Turns gamepad poll samples into connect, button, trigger and stick events.
// ----------------------------------------------------------------------------
// Usage:
//   Push one poll sample on req_ when req_full is low. The front compares it
//   with the stored sample and queues 0 to 19 events; req_full stays high
//   while it scans the candidate events, also while the queue is full.
//   Events leave on rsp_ as a queue: the oldest is shown while rsp_empty is
//   low and leaves when rsp_pop is high. last_event marks the final event of
//   a sample; a sample that changes nothing gives no event.
//   A button or connect event passes the back without division, a trigger
//   event uses at most one division and a stick event at most two, on the
//   shared bit-serial divider.
//   A four-entry queue separates front and back, and the output register
//   lets the back finish its next event while a result waits.
//   When the receiver stalls, the queue fills and req_full rises.
//   Reset clears the stored sample and loads the dead-zone defaults.
//   Write dead zones on csr_ only while no events are pending.
// ----------------------------------------------------------------------------
module gamepad_dead_zone_change_events
   import gdz_pkg::*;
#(
   parameter int VALUE_FRACTION_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);

   logic [7:0]  trig_dz_ff;
   logic [14:0] left_dz_ff, right_dz_ff;
   logic        job_push, job_full, job_pop, job_empty;
   job_type     job_in, job_out;

   // Hold dead-zone registers
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_dz_ff  <= '0;
         left_dz_ff  <= LEFT_DZ_RESET;
         right_dz_ff <= RIGHT_DZ_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TRIG_DZ:  trig_dz_ff  <= csr_data[7:0];
            CSR_LEFT_DZ:  left_dz_ff  <= csr_data;
            CSR_RIGHT_DZ: right_dz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gdz_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .trig_dz  (trig_dz_ff),
      .left_dz  (left_dz_ff),
      .right_dz (right_dz_ff),
      .job_push (job_push),
      .job_data (job_in),
      .job_full (job_full)
   );

   gdz_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   gdz_back #(
      .VALUE_FRACTION_BITS (VALUE_FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (job_out),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_lost_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.event_kind == EV_LOST) |-> rsp_data.last_event)
      else $error("lost event not marked last");
   a_y_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.event_kind != EV_LSTICK &&
       rsp_data.event_kind != EV_RSTICK) |-> (rsp_data.value_y == 16'sd0))
      else $error("value_y set on a non-stick event");
   a_x_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.event_kind == EV_BUTTON ||
       rsp_data.event_kind == EV_ESTABLISHED || rsp_data.event_kind == EV_LOST))
      |-> (rsp_data.value_x == 16'sd0))
      else $error("value_x set on an event without a value");
`endif

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: gamepad change-event emitter testbench
// Drives poll samples through the request queue in random bursts, predicts
// the event stream with a local model of the dead-zone scaling and checks
// every event beat against it, across several dead-zone settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import gdz_pkg::*;

   localparam int FRAC = 14;
   localparam int LIMIT_CYCLES = 1000000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [14:0] csr_data;

   gamepad_dead_zone_change_events #(.VALUE_FRACTION_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor state and settings
   logic [7:0]         trig_dz;
   logic [14:0]        left_dz, right_dz;
   logic               pad_up;
   logic [31:0]        last_packet;
   logic [15:0]        last_buttons;
   logic [7:0]         last_trig [2];
   logic signed [16:0] last_axis [4];

   req_type sample_queue [$];
   rsp_type event_queue [$];
   int      error_count = 0;
   int      event_count = 0;
   int      cycle_count = 0;
   int      burst_left = 0;
   int      gap_left = 0;
   bit      hold_send = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %0s: got %0d expected %0d (event %0d)", what, got, want,
               event_count);
      error_count++;
   endtask

   function automatic int scale_magnitude(int m, int dz, int full);
      longint q;
      if (m <= dz) return 0;
      if (m >= full) q = 1 << FRAC;
      else q = (longint'(m - dz) << FRAC) / (full - dz);
      return q > 32767 ? 32767 : int'(q);
   endfunction

   function automatic int clip_axis(int a, int dz);
      int m = a < 0 ? -a : a;
      if (m <= dz) return 0;
      if (a == -32768) return -32767;
      return a;
   endfunction

   function automatic int scale_axis(int a, int dz);
      int s = scale_magnitude(a < 0 ? -a : a, dz, 32767);
      return a < 0 ? -s : s;
   endfunction

   function automatic rsp_type make_event(logic [2:0] kind, int b, bit p, int x, int y);
      rsp_type e;
      e.event_kind = kind;
      e.button_bit = b[3:0];
      e.button_pressed = p;
      e.value_x = x[15:0];
      e.value_y = y[15:0];
      e.last_event = 0;
      return e;
   endfunction

   task automatic clear_stored();
      last_packet = 0;
      last_buttons = 0;
      for (int i = 0; i < 2; i++) last_trig[i] = 0;
      for (int i = 0; i < 4; i++) last_axis[i] = 0;
   endtask

   // compute the event list of one accepted sample
   task automatic predict_events(input req_type s);
      rsp_type evs [$];
      logic [15:0] changed;
      int t [2];
      int ax [4];
      int raw [4];
      int dz;
      if (!pad_up) begin
         if (!s.controller_present) return;
         pad_up = 1;
         evs.insert(evs.size(), make_event(EV_ESTABLISHED, 0, 0, 0, 0));
      end else if (!s.controller_present) begin
         pad_up = 0;
         clear_stored();
         evs.insert(evs.size(), make_event(EV_LOST, 0, 0, 0, 0));
      end
      if (s.controller_present && s.packet_number != last_packet) begin
         changed = (s.button_word ^ last_buttons) & BUTTON_EVENT_MASK;
         for (int i = 0; i < 16; i++)
            if (changed[i])
               evs.insert(evs.size(), make_event(EV_BUTTON, i, s.button_word[i], 0, 0));
         t[0] = s.left_trigger_raw;
         t[1] = s.right_trigger_raw;
         for (int i = 0; i < 2; i++) begin
            if (t[i] <= trig_dz) t[i] = 0;
            if (t[i] != last_trig[i])
               evs.insert(evs.size(), make_event(i == 0 ? EV_LTRIG : EV_RTRIG, 0, 0,
                  scale_magnitude(t[i], trig_dz, 255), 0));
         end
         raw[0] = s.left_x_raw;  raw[1] = s.left_y_raw;
         raw[2] = s.right_x_raw; raw[3] = s.right_y_raw;
         for (int i = 0; i < 4; i++) ax[i] = clip_axis(raw[i], i < 2 ? left_dz : right_dz);
         for (int i = 0; i < 2; i++) begin
            dz = i == 0 ? left_dz : right_dz;
            if (ax[2*i] != last_axis[2*i] || ax[2*i+1] != last_axis[2*i+1])
               evs.insert(evs.size(), make_event(i == 0 ? EV_LSTICK : EV_RSTICK, 0, 0,
                  scale_axis(ax[2*i], dz), -scale_axis(ax[2*i+1], dz)));
         end
         last_packet = s.packet_number;
         last_buttons = s.button_word;
         for (int i = 0; i < 2; i++) last_trig[i] = t[i];
         for (int i = 0; i < 4; i++) last_axis[i] = ax[i];
      end
      if (evs.size() > 0) evs[evs.size()-1].last_event = 1;
      foreach (evs[i]) event_queue.insert(event_queue.size(), evs[i]);
   endtask

   // driver: push pending samples in bursts, change at the falling edge
   always @(negedge clock) begin
      if (reset || hold_send || sample_queue.size() == 0) begin
         req_push <= 0;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_push <= 0;
      end else begin
         req_push <= 1;
         req_data <= sample_queue[0];
      end
      rsp_pop <= ($urandom_range(0, 9) < 7) || (cycle_count % 400 < 100);
   end

   // accept beats at the rising edge
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         predict_events(sample_queue.pop_front());
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // monitor: compare each event beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (event_queue.size() == 0) begin
            $display("unexpected event beat kind %0d", rsp_data.event_kind);
            error_count++;
         end else begin
            rsp_type w;
            w = event_queue.pop_front();
            if (rsp_data.event_kind !== w.event_kind)
               report_mismatch("event_kind", rsp_data.event_kind, w.event_kind);
            if (rsp_data.button_bit !== w.button_bit)
               report_mismatch("button_bit", rsp_data.button_bit, w.button_bit);
            if (rsp_data.button_pressed !== w.button_pressed)
               report_mismatch("button_pressed", rsp_data.button_pressed, w.button_pressed);
            if (rsp_data.value_x !== w.value_x)
               report_mismatch("value_x", rsp_data.value_x, w.value_x);
            if (rsp_data.value_y !== w.value_y)
               report_mismatch("value_y", rsp_data.value_y, w.value_y);
            if (rsp_data.last_event !== w.last_event)
               report_mismatch("last_event", rsp_data.last_event, w.last_event);
         end
         event_count++;
      end
   end

   function automatic logic signed [15:0] random_axis();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(int'($urandom_range(0, 12000)) - 6000);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic req_type random_sample(input bit present, input logic [31:0] pkt);
      req_type s;
      s.controller_present = present;
      s.packet_number = pkt;
      s.button_word = $urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom());
      s.left_trigger_raw = $urandom_range(0, 4) == 0 ? 8'd255 : 8'($urandom());
      s.right_trigger_raw = $urandom_range(0, 4) == 0 ? 8'd0 : 8'($urandom());
      s.left_x_raw = random_axis();
      s.left_y_raw = random_axis();
      s.right_x_raw = random_axis();
      s.right_y_raw = random_axis();
      return s;
   endfunction

   // wait until the block is idle, including the drain of the back end
   task automatic wait_idle();
      while (sample_queue.size() != 0 || event_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write_enable <= 0;
      case (idx)
         CSR_TRIG_DZ:  trig_dz = val[7:0];
         CSR_LEFT_DZ:  left_dz = val;
         CSR_RIGHT_DZ: right_dz = val;
         default: ;
      endcase
   endtask

   task automatic run_random(input int n);
      logic [31:0] pkt;
      req_type s;
      pkt = $urandom();
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0: s = random_sample(0, $urandom());
            1: s = random_sample(1, pkt);
            default: begin
               pkt = $urandom_range(0, 30) == 0 ? 32'hFFFFFFFF : pkt + 1;
               s = random_sample(1, pkt);
            end
         endcase
         sample_queue.insert(sample_queue.size(), s);
      end
   endtask

   initial begin
      req_type s;
      reset = 1;
      req_push = 0;
      rsp_pop = 0;
      req_data = '0;
      csr_write_enable = 0;
      csr_index = CSR_TRIG_DZ;
      csr_data = '0;
      trig_dz = '0;
      left_dz = LEFT_DZ_RESET;
      right_dz = RIGHT_DZ_RESET;
      pad_up = 0;
      clear_stored();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: absent, appear, extremes, repeat, loss, packet zero after loss
      s = '0;
      sample_queue.insert(sample_queue.size(), s);
      s.controller_present = 1; s.packet_number = 32'd1;
      s.button_word = 16'hFFFF; s.left_trigger_raw = 8'd255; s.right_trigger_raw = 8'd1;
      s.left_x_raw = 16'sh8000; s.left_y_raw = 16'sh7FFF;
      s.right_x_raw = 16'sh7FFF; s.right_y_raw = 16'sh8000;
      sample_queue.insert(sample_queue.size(), s);
      sample_queue.insert(sample_queue.size(), s);
      s.packet_number = 32'hFFFFFFFF; s.button_word = 16'h0C00;
      s.left_x_raw = 16'sd7848; s.left_y_raw = -16'sd7849;
      s.right_x_raw = 16'sd8689; s.right_y_raw = -16'sd8688;
      sample_queue.insert(sample_queue.size(), s);
      s.controller_present = 0;
      sample_queue.insert(sample_queue.size(), s);
      sample_queue.insert(sample_queue.size(), s);
      s = '0; s.controller_present = 1;
      sample_queue.insert(sample_queue.size(), s);
      s.packet_number = 32'd5; s.button_word = 16'h0001; s.left_trigger_raw = 8'd128;
      sample_queue.insert(sample_queue.size(), s);
      wait_idle();

      // settings sweep: defaults, zero, maximum, mid values
      run_random(90);
      wait_idle();
      write_reg(CSR_TRIG_DZ, 15'd0);
      write_reg(CSR_LEFT_DZ, 15'd0);
      write_reg(CSR_RIGHT_DZ, 15'd0);
      run_random(80);
      // pause the sender mid-stream until every expected event has come
      repeat (400) @(posedge clock);
      hold_send = 1;
      while (event_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      hold_send = 0;
      wait_idle();
      write_reg(CSR_TRIG_DZ, 15'd255);
      write_reg(CSR_LEFT_DZ, 15'h7FFF);
      write_reg(CSR_RIGHT_DZ, 15'h7FFE);
      run_random(60);
      wait_idle();
      write_reg(CSR_TRIG_DZ, 15'd30);
      write_reg(CSR_LEFT_DZ, 15'd1000);
      write_reg(CSR_RIGHT_DZ, 15'd20000);
      run_random(120);
      wait_idle();

      $display("tb: covered connect/loss, repeated packets, extreme axes and triggers");
      $display("tb: %0d event beats checked over four dead-zone settings", event_count);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
